### hdl/serial_bank_switch_mapper_assert.svh
// Assertion macros for the serial bank switch mapper.
`ifndef SERIAL_BANK_SWITCH_MAPPER_ASSERT_SVH
`define SERIAL_BANK_SWITCH_MAPPER_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define SBSM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define SBSM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/sbsm_pkg.sv
// Package: types and constants of the serial bank switch mapper.
`default_nettype none

package sbsm_pkg;

    typedef enum logic [1:0] {
        KIND_CPU_READ  = 2'd0,
        KIND_CPU_WRITE = 2'd1,
        KIND_PPU_READ  = 2'd2,
        KIND_PPU_WRITE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        TARGET_PRG_READ  = 2'd0,
        TARGET_CHR_READ  = 2'd1,
        TARGET_CHR_WRITE = 2'd2
    } target_t;

    typedef enum logic [1:0] {
        CFG_PRG_BANK_MASK = 2'd0,
        CFG_CHR_BANK_MASK = 2'd1,
        CFG_CHR_IS_RAM    = 2'd2
    } cfg_index_t;

    // Loader target, picked by address bits 14:13
    typedef enum logic [1:0] {
        SEL_CONTROL  = 2'd0,
        SEL_CHR_LOW  = 2'd1,
        SEL_CHR_HIGH = 2'd2,
        SEL_PRG      = 2'd3
    } latch_sel_t;

    localparam int AddrWidth     = 16;
    localparam int DataWidth     = 8;
    localparam int PhysWidth     = 18;
    localparam int CfgDataWidth  = 5;
    localparam int PrgBankWidth  = 4;
    localparam int ChrBankWidth  = 5;
    localparam int LoaderWidth   = 5;
    localparam int LoaderCntWidth = 3;

    localparam logic [LoaderWidth-1:0]    LoaderReset  = 5'h10;
    localparam logic [LoaderCntWidth-1:0] LoaderLast   = 3'd4;
    localparam logic [LoaderWidth-1:0]    ControlReset = 5'h0C;
    localparam logic [LoaderWidth-1:0]    PrgModeForce = 5'h0C;
    localparam logic [PrgBankWidth-1:0]   PrgMaskReset = 4'hF;
    localparam logic [ChrBankWidth-1:0]   ChrMaskReset = 5'h01;

endpackage

`default_nettype wire

### hdl/serial_bank_switch_mapper.sv
// An accepted transaction passes through the input register and then the result register.
// Throughput: one transaction per cycle; both stages advance whenever the result slot frees.
// CPU writes and PPU writes to CHR ROM, and CPU reads below $8000, give no result.
// Reset (rst_n low, async): pipeline empty, loader 0x10, control 0x0C (PRG mode 3),
// selects zero, prg_bank_mask 15, chr_bank_mask 1, chr_is_ram 0.
`default_nettype none

module serial_bank_switch_mapper (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // configuration
    input  wire logic                                  cfg_write,
    input  wire logic [1:0]                            cfg_index,
    input  wire logic [sbsm_pkg::CfgDataWidth-1:0]     cfg_data,
    // bus access in
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [1:0]                            kind,
    input  wire logic [sbsm_pkg::AddrWidth-1:0]        address,
    input  wire logic [sbsm_pkg::DataWidth-1:0]        write_data,
    // translated access out
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [1:0]                                 target,
    output logic [sbsm_pkg::PhysWidth-1:0]             physical_address,
    output logic [sbsm_pkg::DataWidth-1:0]             store_data
);

    `include "serial_bank_switch_mapper_assert.svh"

    // configuration registers
    logic [sbsm_pkg::PrgBankWidth-1:0] prg_bank_mask_reg;
    logic [sbsm_pkg::ChrBankWidth-1:0] chr_bank_mask_reg;
    logic                              chr_is_ram_reg;

    // mapper state
    logic [sbsm_pkg::LoaderWidth-1:0]    loader_bits_reg, loader_bits_next;
    logic [sbsm_pkg::LoaderCntWidth-1:0] loader_count_reg, loader_count_next;
    logic [sbsm_pkg::LoaderWidth-1:0]    control_reg, control_next;
    logic [sbsm_pkg::PrgBankWidth-1:0]   prg_select_reg, prg_select_next;
    logic [sbsm_pkg::ChrBankWidth-1:0]   chr_low_reg, chr_low_next;
    logic [sbsm_pkg::ChrBankWidth-1:0]   chr_high_reg, chr_high_next;

    // input stage
    logic                                s1_valid_reg;
    sbsm_pkg::kind_t                     s1_kind_reg;
    logic [sbsm_pkg::AddrWidth-1:0]      s1_address_reg;
    logic [sbsm_pkg::DataWidth-1:0]      s1_data_reg;

    // result stage
    logic                                out_valid_reg, res_valid_next;
    sbsm_pkg::target_t                   target_reg, target_next;
    logic [sbsm_pkg::PhysWidth-1:0]      phys_reg, phys_next;
    logic [sbsm_pkg::DataWidth-1:0]      store_reg, store_next;

    logic                                out_free;
    logic                                s1_advance;
    logic                                in_accept;

    logic [1:0]                          prg_mode;
    logic [sbsm_pkg::PrgBankWidth-1:0]   prg_bank;
    logic [sbsm_pkg::ChrBankWidth-1:0]   chr_bank;
    logic [sbsm_pkg::LoaderWidth-1:0]    shifted;
    sbsm_pkg::latch_sel_t                latch_sel;

    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_stall   = s1_valid_reg && !out_free;
    assign in_accept  = in_valid && !in_stall;

    assign out_valid        = out_valid_reg;
    assign target           = target_reg;
    assign physical_address = phys_reg;
    assign store_data       = store_reg;

    // ---------------- translation ----------------
    assign prg_mode = control_reg[3:2];

    always_comb
    begin
        prg_bank = prg_select_reg;
        case (prg_mode)
            2'd0, 2'd1:
            begin
                // 32K mode: upper half is the next bank, wraps within 4 bits
                prg_bank = s1_address_reg[14] ? prg_select_reg + 4'd1 : prg_select_reg;
            end
            2'd2:
            begin
                prg_bank = s1_address_reg[14] ? prg_select_reg : '0;
            end
            default:
            begin
                prg_bank = s1_address_reg[14] ? prg_bank_mask_reg : prg_select_reg;
            end
        endcase
    end

    always_comb
    begin
        if (control_reg[4])
        begin
            chr_bank = s1_address_reg[12] ? chr_high_reg : chr_low_reg;
        end
        else
        begin
            chr_bank = {chr_low_reg[4:1], s1_address_reg[12]};
        end
    end

    // ---------------- state update and result ----------------
    assign shifted   = {s1_data_reg[0], loader_bits_reg[4:1]};
    assign latch_sel = sbsm_pkg::latch_sel_t'(s1_address_reg[14:13]);

    always_comb
    begin
        loader_bits_next  = loader_bits_reg;
        loader_count_next = loader_count_reg;
        control_next      = control_reg;
        prg_select_next   = prg_select_reg;
        chr_low_next      = chr_low_reg;
        chr_high_next     = chr_high_reg;
        res_valid_next    = 1'b0;
        target_next       = sbsm_pkg::TARGET_PRG_READ;
        phys_next         = '0;
        store_next        = '0;

        case (s1_kind_reg)
            sbsm_pkg::KIND_CPU_READ:
            begin
                res_valid_next = s1_address_reg[15];
                target_next    = sbsm_pkg::TARGET_PRG_READ;
                phys_next      = {prg_bank & prg_bank_mask_reg, s1_address_reg[13:0]};
            end
            sbsm_pkg::KIND_CPU_WRITE:
            begin
                if (s1_address_reg[15])
                begin
                    if (s1_data_reg[7])
                    begin
                        loader_bits_next  = sbsm_pkg::LoaderReset;
                        loader_count_next = '0;
                        control_next      = control_reg | sbsm_pkg::PrgModeForce;
                    end
                    else if (loader_count_reg != sbsm_pkg::LoaderLast)
                    begin
                        loader_bits_next  = shifted;
                        loader_count_next = loader_count_reg + 3'd1;
                    end
                    else
                    begin
                        loader_bits_next  = sbsm_pkg::LoaderReset;
                        loader_count_next = '0;
                        case (latch_sel)
                            sbsm_pkg::SEL_CONTROL:  control_next  = shifted;
                            sbsm_pkg::SEL_CHR_LOW:  chr_low_next  = shifted;
                            sbsm_pkg::SEL_CHR_HIGH: chr_high_next = shifted;
                            sbsm_pkg::SEL_PRG:
                            begin
                                // 32K modes drop the low bank bit
                                prg_select_next = {shifted[3:1], shifted[0] & prg_mode[1]};
                            end
                            default: ;
                        endcase
                    end
                end
            end
            sbsm_pkg::KIND_PPU_READ:
            begin
                res_valid_next = 1'b1;
                target_next    = sbsm_pkg::TARGET_CHR_READ;
                phys_next      = {1'b0, chr_bank & chr_bank_mask_reg, s1_address_reg[11:0]};
            end
            sbsm_pkg::KIND_PPU_WRITE:
            begin
                res_valid_next = chr_is_ram_reg;
                target_next    = sbsm_pkg::TARGET_CHR_WRITE;
                phys_next      = {1'b0, chr_bank & chr_bank_mask_reg, s1_address_reg[11:0]};
                store_next     = s1_data_reg;
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_bank_mask_reg <= sbsm_pkg::PrgMaskReset;
            chr_bank_mask_reg <= sbsm_pkg::ChrMaskReset;
            chr_is_ram_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (sbsm_pkg::cfg_index_t'(cfg_index))
                sbsm_pkg::CFG_PRG_BANK_MASK: prg_bank_mask_reg <= cfg_data[3:0];
                sbsm_pkg::CFG_CHR_BANK_MASK: chr_bank_mask_reg <= cfg_data;
                sbsm_pkg::CFG_CHR_IS_RAM:    chr_is_ram_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loader_bits_reg  <= sbsm_pkg::LoaderReset;
            loader_count_reg <= '0;
            control_reg      <= sbsm_pkg::ControlReset;
            prg_select_reg   <= '0;
            chr_low_reg      <= '0;
            chr_high_reg     <= '0;
        end
        else if (s1_advance)
        begin
            loader_bits_reg  <= loader_bits_next;
            loader_count_reg <= loader_count_next;
            control_reg      <= control_next;
            prg_select_reg   <= prg_select_next;
            chr_low_reg      <= chr_low_next;
            chr_high_reg     <= chr_high_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_kind_reg    <= sbsm_pkg::kind_t'(kind);
            s1_address_reg <= address;
            s1_data_reg    <= write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= res_valid_next;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            target_reg <= target_next;
            phys_reg   <= phys_next;
            store_reg  <= store_next;
        end
    end

    // ---------------- assertions ----------------
    `SBSM_ASSERT_ALWAYS(a_loader_count_range, loader_count_reg <= sbsm_pkg::LoaderLast, "loader count past fifth bit")
    `SBSM_ASSERT(a_stall_only_when_full, in_stall |-> s1_valid_reg && out_valid_reg && out_stall, "input stalled with a free slot")
    `SBSM_ASSERT(a_cpu_write_no_result, s1_advance && s1_kind_reg == sbsm_pkg::KIND_CPU_WRITE |=> !out_valid_reg, "CPU write produced a result")
    `SBSM_ASSERT(a_chr_write_needs_ram, out_valid_reg && target_reg == sbsm_pkg::TARGET_CHR_WRITE |-> chr_is_ram_reg, "CHR write issued to ROM")
    `SBSM_ASSERT(a_store_data_zero, out_valid_reg && target_reg != sbsm_pkg::TARGET_CHR_WRITE |-> store_reg == '0, "store data on a read")

endmodule

`default_nettype wire

### dv/serial_bank_switch_mapper_tb.sv
// Testbench for serial_bank_switch_mapper: directed table plus random bus transactions.
`default_nettype none

module serial_bank_switch_mapper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HalfPeriod    = 5;
    localparam int CycleLimit    = 400000;
    localparam int PipeSettle    = 6;
    localparam int HoldOffCycles = 64;
    localparam int PhaseCount    = 6;
    localparam int PhaseItems    = 325;
    localparam int PrintCap      = 100;

    localparam logic [1:0] CfgIndexSpare = 2'd3;

    // Short names for the stimulus table
    localparam sbsm_pkg::kind_t   CpuRd   = sbsm_pkg::KIND_CPU_READ;
    localparam sbsm_pkg::kind_t   CpuWr   = sbsm_pkg::KIND_CPU_WRITE;
    localparam sbsm_pkg::kind_t   PpuRd   = sbsm_pkg::KIND_PPU_READ;
    localparam sbsm_pkg::kind_t   PpuWr   = sbsm_pkg::KIND_PPU_WRITE;
    localparam sbsm_pkg::target_t ToPrg   = sbsm_pkg::TARGET_PRG_READ;
    localparam sbsm_pkg::target_t ToChr   = sbsm_pkg::TARGET_CHR_READ;

    typedef enum logic [1:0] {
        CHK_MODEL = 2'd0,
        CHK_NONE  = 2'd1,
        CHK_FIXED = 2'd2
    } check_t;

    typedef struct packed {
        sbsm_pkg::target_t              tgt;
        logic [sbsm_pkg::PhysWidth-1:0] phys;
        logic [sbsm_pkg::DataWidth-1:0] store;
    } xlate_t;

    typedef struct packed {
        sbsm_pkg::kind_t                op;
        logic [sbsm_pkg::AddrWidth-1:0] addr;
        logic [sbsm_pkg::DataWidth-1:0] data;
        check_t                         check;
        sbsm_pkg::target_t              tgt;
        logic [sbsm_pkg::PhysWidth-1:0] phys;
        logic [sbsm_pkg::DataWidth-1:0] store;
    } stim_row_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_write;
    logic [1:0]                        cfg_index;
    logic [sbsm_pkg::CfgDataWidth-1:0] cfg_data;
    logic                              in_valid;
    logic                              in_stall;
    logic [1:0]                        kind;
    logic [sbsm_pkg::AddrWidth-1:0]    address;
    logic [sbsm_pkg::DataWidth-1:0]    write_data;
    logic                              out_valid;
    logic                              out_stall;
    logic [1:0]                        target;
    logic [sbsm_pkg::PhysWidth-1:0]    physical_address;
    logic [sbsm_pkg::DataWidth-1:0]    store_data;

    serial_bank_switch_mapper i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .address          (address),
        .write_data       (write_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .target           (target),
        .physical_address (physical_address),
        .store_data       (store_data)
    );

    // Shadow copy of the mapper registers and configuration
    logic [sbsm_pkg::PrgBankWidth-1:0]   prg_mask;
    logic [sbsm_pkg::ChrBankWidth-1:0]   chr_mask;
    logic                                chr_ram;
    logic [sbsm_pkg::LoaderWidth-1:0]    ld_bits;
    logic [sbsm_pkg::LoaderCntWidth-1:0] ld_count;
    logic [sbsm_pkg::LoaderWidth-1:0]    ctrl_reg;
    logic [sbsm_pkg::PrgBankWidth-1:0]   prg_bank_sel;
    logic [sbsm_pkg::ChrBankWidth-1:0]   chr_lo_sel;
    logic [sbsm_pkg::ChrBankWidth-1:0]   chr_hi_sel;

    xlate_t pending_xlate[$];
    check_t pin_check;
    xlate_t pin_res;
    bit     idle_on;
    bit     hold_off_req;
    int     mismatches;
    int     accesses_sent;
    int     results_checked;
    int     latch_count;
    int     settings_used;
    int     cycle_count;

    stim_row_t plan [25] = '{
        // reset state: PRG mode 3, CHR 8K, CHR ROM
        '{CpuRd, 16'h8000, 8'h00, CHK_FIXED, ToPrg, 18'h00000, 8'h00},
        '{CpuRd, 16'hFFFF, 8'h00, CHK_FIXED, ToPrg, 18'h3FFFF, 8'h00},
        '{CpuRd, 16'h7FFF, 8'h00, CHK_NONE,  ToPrg, 18'h00000, 8'h00},
        '{PpuRd, 16'h0000, 8'h00, CHK_FIXED, ToChr, 18'h00000, 8'h00},
        '{PpuRd, 16'h1FFF, 8'h00, CHK_FIXED, ToChr, 18'h01FFF, 8'h00},
        '{PpuRd, 16'hFFFF, 8'hFF, CHK_FIXED, ToChr, 18'h01FFF, 8'h00},
        '{PpuWr, 16'h1234, 8'hFF, CHK_NONE,  ToPrg, 18'h00000, 8'h00},
        // PRG select load, with an unselected write in the middle
        '{CpuWr, 16'hE000, 8'h01, CHK_MODEL, ToPrg, 18'h00000, 8'h00},
        '{CpuWr, 16'h7FFF, 8'h00, CHK_MODEL, ToPrg, 18'h00000, 8'h00},
        '{CpuWr, 16'hFFFF, 8'h7F, CHK_MODEL, ToPrg, 18'h00000, 8'h00},
        '{CpuWr, 16'hE000, 8'h00, CHK_MODEL, ToPrg, 18'h00000, 8'h00},
        '{CpuWr, 16'hE000, 8'h01, CHK_MODEL, ToPrg, 18'h00000, 8'h00},
        '{CpuWr, 16'hFFFE, 8'h00, CHK_MODEL, ToPrg, 18'h00000, 8'h00},
        '{CpuRd, 16'h8000, 8'h00, CHK_MODEL, ToPrg, 18'h00000, 8'h00},
        '{CpuRd, 16'hC000, 8'h00, CHK_FIXED, ToPrg, 18'h3C000, 8'h00},
        // partial load aborted by a loader reset, then control = 0x10
        '{CpuWr, 16'h9FFF, 8'h01, CHK_MODEL, ToPrg, 18'h00000, 8'h00},
        '{CpuWr, 16'h8000, 8'hFF, CHK_MODEL, ToPrg, 18'h00000, 8'h00},
        '{CpuWr, 16'h8000, 8'h00, CHK_MODEL, ToPrg, 18'h00000, 8'h00},
        '{CpuWr, 16'h8000, 8'h00, CHK_MODEL, ToPrg, 18'h00000, 8'h00},
        '{CpuWr, 16'h8000, 8'h00, CHK_MODEL, ToPrg, 18'h00000, 8'h00},
        '{CpuWr, 16'h8000, 8'h00, CHK_MODEL, ToPrg, 18'h00000, 8'h00},
        '{CpuWr, 16'h9FFF, 8'h01, CHK_MODEL, ToPrg, 18'h00000, 8'h00},
        // 32K mode with an odd select left over from mode 3
        '{CpuRd, 16'hC000, 8'h00, CHK_MODEL, ToPrg, 18'h00000, 8'h00},
        '{CpuRd, 16'h8000, 8'h00, CHK_MODEL, ToPrg, 18'h00000, 8'h00},
        '{PpuRd, 16'h1000, 8'h00, CHK_MODEL, ToChr, 18'h00000, 8'h00}
    };

    function automatic logic [sbsm_pkg::PhysWidth-1:0] prg_phys(
        input logic [sbsm_pkg::AddrWidth-1:0] a);
        logic [sbsm_pkg::PrgBankWidth-1:0] bank;
        logic                              upper;
        upper = (a >= 16'hC000);
        case (ctrl_reg[3:2])
            2'd0, 2'd1: bank = upper ? prg_bank_sel + 4'd1 : prg_bank_sel;
            2'd2:       bank = upper ? prg_bank_sel : '0;
            default:    bank = upper ? prg_mask : prg_bank_sel;
        endcase
        bank &= prg_mask;
        return {bank, a[13:0]};
    endfunction

    function automatic logic [sbsm_pkg::PhysWidth-1:0] chr_phys(
        input logic [sbsm_pkg::AddrWidth-1:0] a);
        logic [sbsm_pkg::ChrBankWidth-1:0] bank;
        if (ctrl_reg[4])
            bank = a[12] ? chr_hi_sel : chr_lo_sel;
        else
            bank = {chr_lo_sel[4:1], a[12]};
        bank &= chr_mask;
        return {1'b0, bank, a[11:0]};
    endfunction

    // Applies one bus transaction to the shadow state; returns 1 when it yields a result.
    function automatic bit translate_access(input sbsm_pkg::kind_t op,
                                            input logic [sbsm_pkg::AddrWidth-1:0] a,
                                            input logic [sbsm_pkg::DataWidth-1:0] d,
                                            output xlate_t res);
        logic [sbsm_pkg::LoaderWidth-1:0] nxt;
        res = '{sbsm_pkg::TARGET_PRG_READ, '0, '0};
        case (op)
            sbsm_pkg::KIND_CPU_READ:
            begin
                if (a < 16'h8000)
                    return 1'b0;
                res = '{sbsm_pkg::TARGET_PRG_READ, prg_phys(a), '0};
                return 1'b1;
            end
            sbsm_pkg::KIND_CPU_WRITE:
            begin
                if (a < 16'h8000)
                    return 1'b0;
                if (d[7])
                begin
                    ld_bits  = sbsm_pkg::LoaderReset;
                    ld_count = '0;
                    ctrl_reg = ctrl_reg | sbsm_pkg::PrgModeForce;
                    return 1'b0;
                end
                nxt = {d[0], ld_bits[4:1]};
                if (ld_count < sbsm_pkg::LoaderLast)
                begin
                    ld_bits  = nxt;
                    ld_count = ld_count + 3'd1;
                    return 1'b0;
                end
                case (sbsm_pkg::latch_sel_t'(a[14:13]))
                    sbsm_pkg::SEL_CONTROL:  ctrl_reg   = nxt;
                    sbsm_pkg::SEL_CHR_LOW:  chr_lo_sel = nxt;
                    sbsm_pkg::SEL_CHR_HIGH: chr_hi_sel = nxt;
                    default:
                    begin
                        // 32K modes drop the low select bit
                        if (ctrl_reg[3:2] < 2'd2)
                            prg_bank_sel = {nxt[3:1], 1'b0};
                        else
                            prg_bank_sel = nxt[3:0];
                    end
                endcase
                latch_count++;
                ld_bits  = sbsm_pkg::LoaderReset;
                ld_count = '0;
                return 1'b0;
            end
            sbsm_pkg::KIND_PPU_READ:
            begin
                res = '{sbsm_pkg::TARGET_CHR_READ, chr_phys(a), '0};
                return 1'b1;
            end
            default:
            begin
                if (!chr_ram)
                    return 1'b0;
                res = '{sbsm_pkg::TARGET_CHR_WRITE, chr_phys(a), d};
                return 1'b1;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PrintCap)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Called right after a falling edge; returns at the falling edge after acceptance.
    task automatic send_access(input sbsm_pkg::kind_t op,
                               input logic [sbsm_pkg::AddrWidth-1:0] a,
                               input logic [sbsm_pkg::DataWidth-1:0] d);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= op;
        address    <= a;
        write_data <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        accesses_sent++;
    endtask

    task automatic write_setting(input logic [1:0] idx,
                                 input logic [sbsm_pkg::CfgDataWidth-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_xlate.size() != 0)
            @(negedge clk);
        // transactions without a result may still sit in the pipe
        repeat (PipeSettle) @(negedge clk);
    endtask

    task automatic random_traffic(input int count);
        int         sent;
        int         r;
        logic [1:0] sel;
        sent = 0;
        while (sent < count)
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
            begin
                // well-formed five-bit load, occasionally broken or interleaved
                sel = 2'($urandom_range(0, 3));
                for (int i = 0; i < 5; i++)
                begin
                    case ($urandom_range(0, 24))
                        0: send_access(sbsm_pkg::KIND_CPU_WRITE,
                                       16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
                        1:
                        begin
                            send_access(sbsm_pkg::KIND_CPU_WRITE, {1'b1, 15'($urandom)},
                                        8'($urandom) | 8'h80);
                            sent++;
                        end
                        2, 3:
                        begin
                            send_access(sbsm_pkg::KIND_PPU_READ, 16'($urandom),
                                        8'($urandom));
                            sent++;
                        end
                        4:
                        begin
                            send_access(sbsm_pkg::KIND_CPU_READ, {1'b1, 15'($urandom)},
                                        8'($urandom));
                            sent++;
                        end
                        default: ;
                    endcase
                    send_access(sbsm_pkg::KIND_CPU_WRITE, {1'b1, sel, 13'($urandom)},
                                8'($urandom) & 8'h7F);
                    sent++;
                end
            end
            else if (r < 5)
            begin
                send_access(sbsm_pkg::KIND_CPU_READ, {1'b1, 15'($urandom)}, 8'($urandom));
                sent++;
            end
            else if (r == 5)
            begin
                address_noise:
                begin
                    logic [sbsm_pkg::AddrWidth-1:0] a;
                    a = 16'($urandom);
                    send_access(sbsm_pkg::KIND_CPU_READ, a, 8'($urandom));
                    if (a >= 16'h8000)
                        sent++;
                end
            end
            else if (r < 8)
            begin
                send_access(sbsm_pkg::KIND_PPU_READ, 16'($urandom), 8'($urandom));
                sent++;
            end
            else if (r == 8)
            begin
                send_access(sbsm_pkg::KIND_PPU_WRITE, 16'($urandom), 8'($urandom));
                sent++;
            end
            else
            begin
                send_access(sbsm_pkg::KIND_CPU_WRITE, 16'($urandom), 8'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
    end

    always #(HalfPeriod) clk = ~clk;

    // Prediction on accepted inputs, checking on accepted outputs
    always @(posedge clk)
    begin
        xlate_t got;
        xlate_t exp_r;
        xlate_t res;
        bit     has;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{sbsm_pkg::target_t'(target), physical_address, store_data};
                if (pending_xlate.size() == 0)
                    report_mismatch($sformatf("unexpected result target=%0d addr=%05h",
                                              target, physical_address));
                else
                begin
                    exp_r = pending_xlate.pop_front();
                    results_checked++;
                    if (got.tgt !== exp_r.tgt)
                        report_mismatch($sformatf("target %0d, expected %0d",
                                                  got.tgt, exp_r.tgt));
                    if (got.phys !== exp_r.phys)
                        report_mismatch($sformatf("physical_address %05h, expected %05h",
                                                  got.phys, exp_r.phys));
                    if (got.store !== exp_r.store)
                        report_mismatch($sformatf("store_data %02h, expected %02h",
                                                  got.store, exp_r.store));
                end
            end
            if (in_valid && !in_stall)
            begin
                has = translate_access(sbsm_pkg::kind_t'(kind), address, write_data, res);
                if (pin_check == CHK_NONE)
                    has = 1'b0;
                else if (pin_check == CHK_FIXED)
                begin
                    has = 1'b1;
                    res = pin_res;
                end
                if (has)
                    pending_xlate.push_back(res);
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    sbsm_pkg::CFG_PRG_BANK_MASK:
                        prg_mask = cfg_data[sbsm_pkg::PrgBankWidth-1:0];
                    sbsm_pkg::CFG_CHR_BANK_MASK: chr_mask = cfg_data;
                    sbsm_pkg::CFG_CHR_IS_RAM:    chr_ram  = cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Result side: random stall bursts plus one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HoldOffCycles) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [sbsm_pkg::CfgDataWidth-1:0] prg_plan [PhaseCount];
        logic [sbsm_pkg::CfgDataWidth-1:0] chr_plan [PhaseCount];
        logic                              ram_plan [PhaseCount];
        prg_plan = '{5'd0, 5'd15, 5'd7, 5'd0, 5'd3, 5'd15};
        chr_plan = '{5'd0, 5'd31, 5'd3, 5'd0, 5'd15, 5'd1};
        ram_plan = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = sbsm_pkg::CFG_PRG_BANK_MASK;
        cfg_data     = '0;
        in_valid     = 1'b0;
        kind         = sbsm_pkg::KIND_CPU_READ;
        address      = '0;
        write_data   = '0;
        idle_on      = 1'b1;
        hold_off_req = 1'b0;
        pin_check    = CHK_MODEL;
        pin_res      = '{sbsm_pkg::TARGET_PRG_READ, '0, '0};
        mismatches      = 0;
        accesses_sent   = 0;
        results_checked = 0;
        latch_count     = 0;
        settings_used   = 1;

        prg_mask     = sbsm_pkg::PrgMaskReset;
        chr_mask     = sbsm_pkg::ChrMaskReset;
        chr_ram      = 1'b0;
        ld_bits      = sbsm_pkg::LoaderReset;
        ld_count     = '0;
        ctrl_reg     = sbsm_pkg::ControlReset;
        prg_bank_sel = '0;
        chr_lo_sel   = '0;
        chr_hi_sel   = '0;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            pin_check = plan[i].check;
            pin_res   = '{plan[i].tgt, plan[i].phys, plan[i].store};
            send_access(plan[i].op, plan[i].addr, plan[i].data);
        end
        pin_check = CHK_MODEL;

        for (int ph = 0; ph < PhaseCount; ph++)
        begin
            drain_results();
            if (ph == 3)
            begin
                prg_plan[ph] = 5'($urandom_range(0, 15));
                chr_plan[ph] = 5'($urandom_range(0, 31));
                ram_plan[ph] = 1'($urandom_range(0, 1));
                // spare index must not disturb anything
                write_setting(CfgIndexSpare, 5'($urandom));
            end
            write_setting(sbsm_pkg::CFG_PRG_BANK_MASK, prg_plan[ph]);
            write_setting(sbsm_pkg::CFG_CHR_BANK_MASK, chr_plan[ph]);
            write_setting(sbsm_pkg::CFG_CHR_IS_RAM, 5'(ram_plan[ph]));
            settings_used++;
            idle_on = (ph != PhaseCount - 1);
            if (ph == 1)
                hold_off_req = 1'b1;
            random_traffic(PhaseItems);
        end

        in_valid <= 1'b0;
        while (pending_xlate.size() != 0)
            @(negedge clk);
        repeat (PipeSettle) @(negedge clk);

        $display("Covered %0d bus transactions, %0d translated results checked,",
                 accesses_sent, results_checked);
        $display("%0d loader latches across %0d bank mask / CHR RAM settings.",
                 latch_count, settings_used);
        if (mismatches == 0 && pending_xlate.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
+incdir+hdl
hdl/sbsm_pkg.sv
hdl/serial_bank_switch_mapper.sv
dv/serial_bank_switch_mapper_tb.sv
